### rtl/sme_pkg.sv
// sme_pkg: sizes, configuration and step types, and delay helpers for the stereo echo core
// no dependencies; imported by every module of the block but sme_ram
`default_nettype none

package sme_pkg;

    localparam int BUF_DEPTH     = 65536;
    localparam int SAMPLE_BITS   = 24;
    localparam int TAP_COUNT     = 3;

    localparam int ADDR_BITS     = $clog2(BUF_DEPTH);
    localparam int DELAY_BITS    = 16;
    localparam int GAIN_BITS     = 15;
    localparam int FRAC_BITS     = 15;
    localparam int COEF_BITS     = GAIN_BITS + 1;
    localparam int TAP_BITS      = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int STEP_BITS     = $clog2(TAP_COUNT + 1);
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS + 1;
    localparam int ACC_BITS      = PROD_BITS + $clog2(TAP_COUNT + 1);
    localparam int STORE_BITS    = 2 * SAMPLE_BITS;

    // register map
    localparam int NUM_REGS       = 2 + 2 * TAP_COUNT;
    localparam int REG_ENABLE     = 0;
    localparam int REG_WET_ONLY   = 1;
    localparam int REG_DELAY_BASE = 2;
    localparam int REG_GAIN_BASE  = 2 + TAP_COUNT;
    localparam int CFG_IDX_BITS   = $clog2(NUM_REGS + 1);
    localparam int CFG_DATA_BITS  = 16;

    // dry path weight, unity in Q1.15
    localparam logic [COEF_BITS-1:0] DRY_COEF = COEF_BITS'(1 << FRAC_BITS);

    // conditional subtract steps that fold a 16-bit delay into the store depth
    localparam int RED_STEPS = 7;

    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                                enable;
        logic                                wet_only;
        logic [TAP_COUNT-1:0][ADDR_BITS-1:0] delay;
        logic [TAP_COUNT-1:0][GAIN_BITS-1:0] gain;
    } cfg_t;

    // one store access of the sequencer, as seen by the multiply-accumulate
    typedef struct packed {
        logic                 valid;
        logic                 dry;
        logic                 last;
        logic                 live;
        logic [COEF_BITS-1:0] coef;
    } step_t;

    function automatic addr_t wrap_delay(input logic [DELAY_BITS-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (v >= (32'(BUF_DEPTH) << k)) begin
                v = v - (32'(BUF_DEPTH) << k);
            end
        end
        return ADDR_BITS'(v);
    endfunction

    function automatic logic [DELAY_BITS-1:0] delay_reset(input int k);
        case (k)
            0:       return 16'd15435;
            1:       return 16'd30870;
            2:       return 16'd46305;
            default: return 16'd0;
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] gain_reset(input int k);
        case (k)
            0:       return 15'd16384;
            1:       return 15'd9830;
            2:       return 15'd4915;
            default: return 15'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/stereo_multitap_echo_core.sv
// stereo_multitap_echo_core: top level of the stereo multitap echo
// depends on sme_pkg, sme_regs, sme_seq, sme_ram, sme_mac
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_left_in, s_right_in
//   m_        out        m_valid / m_ready     m_left_out, m_right_out
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// echo on: one write and one read per tap on the single store port for each word; the next
// word is taken at the last read; sums pass the product, result and output registers
// echo off: one word per cycle, unless the m_ side stalls, straight into the output register
// no clearing pass after reset: write pointer and wrap flag make unwritten entries read zero
// at most two words in flight while echo is on; a stalled m_ side holds them there
`default_nettype none

module stereo_multitap_echo_core
    import sme_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire sample_t                  s_left_in,
    input  wire sample_t                  s_right_in,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output sample_t                       m_left_out,
    output sample_t                       m_right_out,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t                  cfg;
    logic                  seq_free;
    logic                  ram_en;
    logic                  ram_we;
    addr_t                 ram_addr;
    logic [STORE_BITS-1:0] ram_wdata;
    logic [STORE_BITS-1:0] ram_rdata;
    step_t                 step;
    sample_t               dry_left;
    sample_t               dry_right;

    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic                  deliver;
    logic                  accept;
    logic                  start;
    logic                  byp_load;
    sample_t               byp_left;
    sample_t               byp_right;

    assign deliver = m_valid && m_ready;

    always_comb begin
        if (cfg.enable) begin
            s_ready = seq_free && ((cnt_reg < 2'd2) || deliver);
        end else begin
            s_ready = !m_valid || m_ready;
        end
    end

    assign accept    = s_valid && s_ready;
    assign start     = accept && cfg.enable;
    assign byp_load  = accept && !cfg.enable;
    assign byp_left  = cfg.wet_only ? '0 : s_left_in;
    assign byp_right = cfg.wet_only ? '0 : s_right_in;

    // words accepted on the echo path and not yet delivered
    always_comb begin
        cnt_next = cnt_reg;
        if (start && !(deliver && cfg.enable)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!start && deliver && cfg.enable) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    sme_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sme_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .start     (start),
        .left_in   (s_left_in),
        .right_in  (s_right_in),
        .free      (seq_free),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .step      (step),
        .dry_left  (dry_left),
        .dry_right (dry_right)
    );

    sme_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (STORE_BITS)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sme_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .dry_left    (dry_left),
        .dry_right   (dry_right),
        .rdata       (ram_rdata),
        .byp_load    (byp_load),
        .byp_left    (byp_left),
        .byp_right   (byp_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule

`default_nettype wire

### rtl/sme_ram.sv
// sme_ram: generic single-port synchronous RAM, one access a cycle, registered read
// no dependencies
`default_nettype none

module sme_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/sme_regs.sv
// sme_regs: configuration register file with write decode
// depends on sme_pkg
`default_nettype none

module sme_regs
    import sme_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable   <= 1'b0;
            cfg_reg.wet_only <= 1'b0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                cfg_reg.delay[k] <= wrap_delay(delay_reset(k));
                cfg_reg.gain[k]  <= gain_reset(k);
            end
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IDX_BITS'(REG_ENABLE)) begin
                cfg_reg.enable <= cfg_data[0];
            end
            if (cfg_index == CFG_IDX_BITS'(REG_WET_ONLY)) begin
                cfg_reg.wet_only <= cfg_data[0];
            end
            for (int k = 0; k < TAP_COUNT; k++) begin
                // delays are stored already folded into the store depth
                if (cfg_index == CFG_IDX_BITS'(REG_DELAY_BASE + k)) begin
                    cfg_reg.delay[k] <= wrap_delay(cfg_data[DELAY_BITS-1:0]);
                end
                if (cfg_index == CFG_IDX_BITS'(REG_GAIN_BASE + k)) begin
                    cfg_reg.gain[k] <= cfg_data[GAIN_BITS-1:0];
                end
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/sme_seq.sv
// sme_seq: per-word access sequencer for the delay store; one write then one read per tap,
// write pointer and fill tracking. depends on sme_pkg
`default_nettype none

module sme_seq
    import sme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  start,
    input  wire sample_t               left_in,
    input  wire sample_t               right_in,
    output logic                       free,
    output logic                       ram_en,
    output logic                       ram_we,
    output addr_t                      ram_addr,
    output logic [STORE_BITS-1:0]      ram_wdata,
    output step_t                      step,
    output sample_t                    dry_left,
    output sample_t                    dry_right
);

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TAP_COUNT);

    logic                 busy_reg;
    logic [STEP_BITS-1:0] st_reg;
    addr_t                wp_reg;
    logic                 wrapped_reg;
    sample_t              left_reg;
    sample_t              right_reg;

    logic                 is_write;
    logic                 is_last;
    logic [TAP_BITS-1:0]  tap_idx;
    addr_t                tap_delay;
    logic [ADDR_BITS:0]   back;
    addr_t                rd_addr;
    logic                 filled;

    assign is_write = (st_reg == '0);
    assign is_last  = (st_reg == LAST_STEP);
    assign tap_idx  = is_write ? '0 : TAP_BITS'(st_reg - STEP_BITS'(1));
    assign tap_delay = cfg.delay[tap_idx];

    // read address is the write pointer minus the delay, modulo the depth
    assign back    = {1'b0, wp_reg} + (ADDR_BITS+1)'(BUF_DEPTH) - {1'b0, tap_delay};
    assign rd_addr = (back >= (ADDR_BITS+1)'(BUF_DEPTH)) ?
                     ADDR_BITS'(back - (ADDR_BITS+1)'(BUF_DEPTH)) : ADDR_BITS'(back);
    // entries not yet written since reset read as zero
    assign filled  = wrapped_reg || (rd_addr <= wp_reg);

    assign free = !busy_reg || is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            st_reg      <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            if (busy_reg && is_last) begin
                busy_reg <= 1'b0;
                if (wp_reg == ADDR_BITS'(BUF_DEPTH - 1)) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + ADDR_BITS'(1);
                end
            end
            if (start) begin
                busy_reg <= 1'b1;
                st_reg   <= '0;
            end else if (busy_reg && !is_last) begin
                st_reg <= st_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            left_reg  <= left_in;
            right_reg <= right_in;
        end
    end

    assign ram_en    = busy_reg;
    assign ram_we    = busy_reg && is_write;
    assign ram_addr  = is_write ? wp_reg : rd_addr;
    assign ram_wdata = {left_reg, right_reg};

    always_comb begin
        step.valid = busy_reg;
        step.dry   = is_write;
        step.last  = is_last;
        step.live  = is_write || filled;
        if (is_write) begin
            step.coef = cfg.wet_only ? '0 : DRY_COEF;
        end else begin
            step.coef = {1'b0, cfg.gain[tap_idx]};
        end
    end

    assign dry_left  = left_reg;
    assign dry_right = right_reg;

endmodule

`default_nettype wire

### rtl/sme_mac.sv
// sme_mac: tap multiply, accumulate, round and saturate, and the output word register
// depends on sme_pkg
`default_nettype none

module sme_mac
    import sme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire step_t                 step,
    input  wire sample_t               dry_left,
    input  wire sample_t               dry_right,
    input  wire logic [STORE_BITS-1:0] rdata,
    input  wire logic                  byp_load,
    input  wire sample_t               byp_left,
    input  wire sample_t               byp_right,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sample_t                    m_left_out,
    output sample_t                    m_right_out
);

    localparam longint SAT_HI_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_BITS:0] SAT_HI = (ACC_BITS+1)'(SAT_HI_L);
    localparam logic signed [ACC_BITS:0] SAT_LO = (ACC_BITS+1)'(-SAT_HI_L - 1);
    localparam logic signed [ACC_BITS:0] ROUND_HALF = (ACC_BITS+1)'(1 << (FRAC_BITS - 1));

    step_t                       s1_reg;
    sample_t                     s1_dry_l_reg;
    sample_t                     s1_dry_r_reg;
    step_t                       s2_reg;
    logic signed [PROD_BITS-1:0] prod_l_reg;
    logic signed [PROD_BITS-1:0] prod_r_reg;
    logic signed [ACC_BITS-1:0]  acc_l_reg;
    logic signed [ACC_BITS-1:0]  acc_r_reg;
    logic signed [ACC_BITS-1:0]  res_l_reg;
    logic signed [ACC_BITS-1:0]  res_r_reg;
    logic                        res_valid_reg;
    logic                        m_valid_reg;
    sample_t                     out_l_reg;
    sample_t                     out_r_reg;

    sample_t                     data_l;
    sample_t                     data_r;
    logic signed [ACC_BITS-1:0]  sum_l;
    logic signed [ACC_BITS-1:0]  sum_r;
    logic                        out_free;
    logic                        res_move;

    function automatic sample_t round_sat(input logic signed [ACC_BITS-1:0] a);
        logic signed [ACC_BITS:0] biased;
        logic signed [ACC_BITS:0] q;
        biased = (ACC_BITS+1)'(a) + ROUND_HALF;
        q      = biased >>> FRAC_BITS;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return SAMPLE_BITS'(q);
    endfunction

    // store word: left in the upper half
    always_comb begin
        if (!s1_reg.live) begin
            data_l = '0;
            data_r = '0;
        end else if (s1_reg.dry) begin
            data_l = s1_dry_l_reg;
            data_r = s1_dry_r_reg;
        end else begin
            data_l = rdata[STORE_BITS-1:SAMPLE_BITS];
            data_r = rdata[SAMPLE_BITS-1:0];
        end
    end

    // dry term opens each word's sum
    assign sum_l = (s2_reg.dry ? '0 : acc_l_reg) + ACC_BITS'(prod_l_reg);
    assign sum_r = (s2_reg.dry ? '0 : acc_r_reg) + ACC_BITS'(prod_r_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign res_move = res_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_reg <= step;
            s2_reg <= s1_reg;
            if (s2_reg.valid && s2_reg.last) begin
                res_valid_reg <= 1'b1;
            end else if (res_move) begin
                res_valid_reg <= 1'b0;
            end
            if (byp_load || res_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_dry_l_reg <= dry_left;
        s1_dry_r_reg <= dry_right;

        prod_l_reg  <= $signed(data_l) * $signed({1'b0, s1_reg.coef});
        prod_r_reg  <= $signed(data_r) * $signed({1'b0, s1_reg.coef});

        if (s2_reg.valid) begin
            if (s2_reg.last) begin
                res_l_reg <= sum_l;
                res_r_reg <= sum_r;
            end else begin
                acc_l_reg <= sum_l;
                acc_r_reg <= sum_r;
            end
        end

        if (byp_load) begin
            out_l_reg <= byp_left;
            out_r_reg <= byp_right;
        end else if (res_move) begin
            out_l_reg <= round_sat(res_l_reg);
            out_r_reg <= round_sat(res_r_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_l_reg;
    assign m_right_out = out_r_reg;

endmodule

`default_nettype wire
